// ===== sv/i2cram_pkg.sv =====
// Package for the I2C register access master: item types, command codes and limits.
// No dependencies; every other file in this folder uses it.
package i2cram_pkg;

    // Command codes carried by an input word.
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;
    localparam logic [1:0] CMD_BURST = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_DEVICE_ADDRESS = 2'd0;
    localparam logic [1:0] CFG_BURST_START    = 2'd1;
    localparam logic [1:0] CFG_BURST_LENGTH   = 2'd2;

    // Configuration reset values.
    localparam logic [6:0] DEVICE_ADDRESS_RST = 7'h1e;
    localparam logic [7:0] BURST_START_RST    = 8'h03;
    localparam logic [3:0] BURST_LENGTH_RST   = 4'd6;

    // Largest number of bytes in one burst read.
    localparam logic [3:0] MAX_BURST = 4'd8;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 16;

    typedef struct packed {
        logic [6:0] device_address;
        logic [7:0] burst_start_register;
        logic [3:0] burst_length;
    } t_cfg;

    typedef struct packed {
        logic       sda_in;
        logic [7:0] write_data;
        logic [7:0] target_reg;
        logic [1:0] command;
    } t_in_item;

    typedef struct packed {
        logic       slave_nack;
        logic       ack_valid;
        logic       last_byte;
        logic [7:0] read_byte;
        logic       byte_valid;
        logic       busy_res;
        logic       sda_pull_low;
        logic       scl_level;
    } t_result;

endpackage

// ===== sv/i2cram_cfg.sv =====
// Configuration registers of the I2C register access master.
// Depends on i2cram_pkg.
module i2cram_cfg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_we,
    input  logic [1:0]         i_index,
    input  logic [7:0]         i_wdata,
    output i2cram_pkg::t_cfg   o_cfg
);

    i2cram_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.device_address       <= i2cram_pkg::DEVICE_ADDRESS_RST;
            r_cfg.burst_start_register <= i2cram_pkg::BURST_START_RST;
            r_cfg.burst_length         <= i2cram_pkg::BURST_LENGTH_RST;
        end else if (i_we) begin
            unique case (i_index)
                i2cram_pkg::CFG_DEVICE_ADDRESS: r_cfg.device_address       <= i_wdata[6:0];
                i2cram_pkg::CFG_BURST_START:    r_cfg.burst_start_register <= i_wdata;
                i2cram_pkg::CFG_BURST_LENGTH:   r_cfg.burst_length         <= i_wdata[3:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== sv/i2cram_core.sv =====
// Bus sequencer of the I2C register access master: one half-bit of the bus per word.
// Depends on i2cram_pkg.
module i2cram_core #(
    parameter logic [3:0] MAX_BURST = i2cram_pkg::MAX_BURST
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  i2cram_pkg::t_in_item   i_item,
    input  i2cram_pkg::t_cfg       i_cfg,
    output i2cram_pkg::t_result    o_result
);

    typedef enum logic [4:0] {
        PH_IDLE, PH_START_FALL, PH_TX_ADDR_W, PH_ACK_ADDR_W, PH_TX_REG, PH_ACK_REG,
        PH_TX_DATA, PH_ACK_DATA, PH_RS_LOW, PH_RS_SETUP, PH_RS_FALL, PH_TX_ADDR_R,
        PH_ACK_ADDR_R, PH_RX_BYTE, PH_MACK, PH_STOP_LOW, PH_STOP_HIGH, PH_STOP_RISE
    } t_phase;

    t_phase     r_phase,   n_phase;
    logic [2:0] r_bit_cnt, n_bit_cnt;
    logic       r_toggle,  n_toggle;
    logic [7:0] r_shift,   n_shift;
    logic [3:0] r_remain,  n_remain;
    logic [1:0] r_cmd,     n_cmd;
    logic [7:0] r_reg,     n_reg;
    logic [7:0] r_data,    n_data;

    i2cram_pkg::t_result res;
    logic [3:0]          burst_n;
    logic [7:0]          rx_shift;
    logic                final_byte;

    always_comb begin
        burst_n = i_cfg.burst_length;
        if (burst_n == 4'd0) begin
            burst_n = 4'd1;
        end
        if (burst_n > MAX_BURST) begin
            burst_n = MAX_BURST;
        end
        rx_shift   = {r_shift[6:0], i_item.sda_in};
        final_byte = (r_remain <= 4'd1);
    end

    always_comb begin
        n_phase   = r_phase;
        n_bit_cnt = r_bit_cnt;
        n_toggle  = r_toggle;
        n_shift   = r_shift;
        n_remain  = r_remain;
        n_cmd     = r_cmd;
        n_reg     = r_reg;
        n_data    = r_data;
        res              = '0;
        res.scl_level    = 1'b1;
        res.busy_res     = 1'b1;

        unique case (r_phase)
            PH_IDLE: begin
                if (i_item.command == i2cram_pkg::CMD_TICK) begin
                    res.busy_res = 1'b0;
                end else begin
                    n_cmd  = i_item.command;
                    n_data = i_item.write_data;
                    if (i_item.command == i2cram_pkg::CMD_BURST) begin
                        n_reg    = i_cfg.burst_start_register;
                        n_remain = burst_n;
                    end else begin
                        n_reg    = i_item.target_reg;
                        n_remain = 4'd1;
                    end
                    n_phase = PH_START_FALL;
                end
            end
            PH_START_FALL, PH_RS_FALL: begin
                res.sda_pull_low = 1'b1;
                n_bit_cnt = '0;
                n_toggle  = 1'b0;
                if (r_phase == PH_START_FALL) begin
                    n_phase = PH_TX_ADDR_W;
                    n_shift = {i_cfg.device_address, 1'b0};
                end else begin
                    n_phase = PH_TX_ADDR_R;
                    n_shift = {i_cfg.device_address, 1'b1};
                end
            end
            PH_RS_LOW: begin
                res.scl_level = 1'b0;
                n_phase = PH_RS_SETUP;
            end
            PH_RS_SETUP: begin
                n_phase = PH_RS_FALL;
            end
            PH_TX_ADDR_W, PH_TX_REG, PH_TX_DATA, PH_TX_ADDR_R: begin
                res.sda_pull_low = ~r_shift[7];
                if (!r_toggle) begin
                    res.scl_level = 1'b0;
                    n_toggle = 1'b1;
                end else begin
                    n_toggle = 1'b0;
                    n_shift  = {r_shift[6:0], 1'b0};
                    n_bit_cnt = r_bit_cnt + 3'd1;
                    if (r_bit_cnt == 3'd7) begin
                        case (r_phase)
                            PH_TX_ADDR_W: n_phase = PH_ACK_ADDR_W;
                            PH_TX_REG:    n_phase = PH_ACK_REG;
                            PH_TX_DATA:   n_phase = PH_ACK_DATA;
                            default:      n_phase = PH_ACK_ADDR_R;
                        endcase
                    end
                end
            end
            PH_ACK_ADDR_W, PH_ACK_REG, PH_ACK_DATA, PH_ACK_ADDR_R: begin
                if (!r_toggle) begin
                    res.scl_level = 1'b0;
                    n_toggle = 1'b1;
                end else begin
                    n_toggle       = 1'b0;
                    res.ack_valid  = 1'b1;
                    res.slave_nack = i_item.sda_in;
                    n_bit_cnt      = '0;
                    case (r_phase)
                        PH_ACK_ADDR_W: begin
                            n_phase = PH_TX_REG;
                            n_shift = r_reg;
                        end
                        PH_ACK_REG: begin
                            if (r_cmd == i2cram_pkg::CMD_WRITE) begin
                                n_phase = PH_TX_DATA;
                                n_shift = r_data;
                            end else begin
                                n_phase   = PH_RS_LOW;
                                n_bit_cnt = r_bit_cnt;
                            end
                        end
                        PH_ACK_DATA: begin
                            n_phase   = PH_STOP_LOW;
                            n_bit_cnt = r_bit_cnt;
                        end
                        default: begin
                            n_phase = PH_RX_BYTE;
                            n_shift = '0;
                        end
                    endcase
                end
            end
            PH_RX_BYTE: begin
                if (!r_toggle) begin
                    res.scl_level = 1'b0;
                    n_toggle = 1'b1;
                end else begin
                    n_toggle  = 1'b0;
                    n_shift   = rx_shift;
                    n_bit_cnt = r_bit_cnt + 3'd1;
                    if (r_bit_cnt == 3'd7) begin
                        res.byte_valid = 1'b1;
                        res.read_byte  = rx_shift;
                        res.last_byte  = final_byte;
                        n_phase        = PH_MACK;
                    end
                end
            end
            PH_MACK: begin
                // Master acknowledges every byte but the last one of the run.
                res.sda_pull_low = ~final_byte;
                if (!r_toggle) begin
                    res.scl_level = 1'b0;
                    n_toggle = 1'b1;
                end else begin
                    n_toggle = 1'b0;
                    if (final_byte) begin
                        n_remain = '0;
                        n_phase  = PH_STOP_LOW;
                    end else begin
                        n_remain  = r_remain - 4'd1;
                        n_phase   = PH_RX_BYTE;
                        n_shift   = '0;
                        n_bit_cnt = '0;
                    end
                end
            end
            PH_STOP_LOW: begin
                res.scl_level    = 1'b0;
                res.sda_pull_low = 1'b1;
                n_phase = PH_STOP_HIGH;
            end
            PH_STOP_HIGH: begin
                res.sda_pull_low = 1'b1;
                n_phase = PH_STOP_RISE;
            end
            PH_STOP_RISE: begin
                n_phase = PH_IDLE;
            end
            default: begin
                res.busy_res = 1'b0;
                n_phase = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_bit_cnt <= '0;
            r_toggle  <= 1'b0;
            r_shift   <= '0;
            r_remain  <= '0;
            r_cmd     <= '0;
            r_reg     <= '0;
            r_data    <= '0;
        end else if (i_en) begin
            r_phase   <= n_phase;
            r_bit_cnt <= n_bit_cnt;
            r_toggle  <= n_toggle;
            r_shift   <= n_shift;
            r_remain  <= n_remain;
            r_cmd     <= n_cmd;
            r_reg     <= n_reg;
            r_data    <= n_data;
        end
    end

    assign o_result = res;

    // A received byte and a slave acknowledge never fall on the same half-bit.
    a_no_byte_and_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(res.byte_valid && res.ack_valid))
        else $error("byte and acknowledge reported together");

    // The byte count never exceeds the burst limit.
    a_remain_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_remain <= MAX_BURST)
        else $error("byte count above burst limit");

    // While bytes are received at least one is still owed.
    a_remain_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_RX_BYTE || r_phase == PH_MACK) |-> r_remain != 4'd0)
        else $error("receiving with no bytes left");

    // An accepted command in idle always leads into the start condition.
    a_start_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && r_phase == PH_IDLE && i_item.command != i2cram_pkg::CMD_TICK)
        |=> r_phase == PH_START_FALL)
        else $error("command accepted without start condition");

endmodule

// ===== sv/i2c_register_access_master.sv =====
// Top level of the I2C register access master: input register, bus sequencer, result register.
// Depends on i2cram_pkg, i2cram_cfg and i2cram_core.
//
//  channel   | direction | carries
//  s_axis    | in        | one bus half-bit tick: command, register, data, sampled SDA
//  m_axis    | out       | line levels, busy, received byte, acknowledge for that tick
//  i_cfg_*   | in        | register writes: device address, burst start, burst length
//
// Every accepted word gives exactly one result word via the input and result registers; one
// word per cycle is sustained while m_axis is ready, the sequencer state advancing once per word.
// Reset clears the sequencer to idle and restores the register defaults.
// A stall on m_axis holds the result register and then the input register; s_axis
// stays ready while the result register can drain in the same cycle.
module i2c_register_access_master #(
    parameter logic [3:0] MAX_BURST = i2cram_pkg::MAX_BURST
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [1:0] command, [9:2] target_reg, [17:10] write_data, [18] sda_in, [23:19] zero
    input  logic [i2cram_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [0] scl_level, [1] sda_pull_low, [2] busy_res, [3] byte_valid, [11:4] read_byte,
    // [12] ack_valid, [13] slave_nack, [15:14] zero
    output logic [i2cram_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    output logic                                m_axis_tlast,
    input  logic                                i_cfg_we,
    input  logic [1:0]                          i_cfg_index,
    input  logic [7:0]                          i_cfg_wdata
);

    i2cram_pkg::t_cfg      cfg;
    i2cram_pkg::t_in_item  r_in;
    logic                  r_in_valid;
    i2cram_pkg::t_result   r_out;
    logic                  r_out_valid;
    i2cram_pkg::t_result   core_res;
    logic                  advance;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    i2cram_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_index (i_cfg_index),
        .i_wdata (i_cfg_wdata),
        .o_cfg   (cfg)
    );

    i2cram_core #(
        .MAX_BURST (MAX_BURST)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (advance),
        .i_item   (r_in),
        .i_cfg    (cfg),
        .o_result (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in <= s_axis_tdata[18:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= core_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out.last_byte;
    assign m_axis_tdata  = {2'b00, r_out.slave_nack, r_out.ack_valid, r_out.read_byte,
                            r_out.byte_valid, r_out.busy_res, r_out.sda_pull_low,
                            r_out.scl_level};

endmodule
